// ===== hw/rtl/fnvh_pkg.sv =====
// shared types, constants and hash step functions for the fnv byte stream hash
`default_nettype none
package fnvh_pkg;

    localparam int MAX_HASH_BITS = 256;
    localparam int STATE_BITS    = 256;
    localparam int WORD_BITS     = 64;
    localparam int NUM_WORDS     = STATE_BITS / WORD_BITS;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 2;
    localparam int CNT_W         = 3;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_VARIANT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SEL = 2'd1;

    // width select codes
    localparam logic [1:0] SEL_32  = 2'd0;
    localparam logic [1:0] SEL_64  = 2'd1;
    localparam logic [1:0] SEL_128 = 2'd2;
    localparam logic [1:0] SEL_256 = 2'd3;

    // largest width code that fits MAX_HASH_BITS, never below 32 bits
    localparam logic [1:0] SEL_MAX = (MAX_HASH_BITS >= 256) ? SEL_256 :
                                     (MAX_HASH_BITS >= 128) ? SEL_128 :
                                     (MAX_HASH_BITS >= 64)  ? SEL_64  : SEL_32;

    // prime = 2^shift + low
    localparam logic [8:0] PRIME_LOW_32  = 9'h193;
    localparam logic [8:0] PRIME_LOW_64  = 9'h1b3;
    localparam logic [8:0] PRIME_LOW_128 = 9'h13b;
    localparam logic [8:0] PRIME_LOW_256 = 9'h163;

    localparam logic [STATE_BITS-1:0] BASIS_32  = {224'd0, 32'h811c9dc5};
    localparam logic [STATE_BITS-1:0] BASIS_64  = {192'd0, 64'hcbf29ce484222325};
    localparam logic [STATE_BITS-1:0] BASIS_128 = {128'd0, 64'h6c62272e07bb0142,
                                                   64'h62b821756295c58d};
    localparam logic [STATE_BITS-1:0] BASIS_256 = {64'hdd268dbcaac55036,
                                                   64'h2d98c384c4e576cc,
                                                   64'hc8b1536847b6bbb3,
                                                   64'h1023b4c8caee0535};

    // one finished hash handed to the output side
    typedef struct packed {
        logic                                valid;
        logic [CNT_W-1:0]                    cnt;
        logic [NUM_WORDS-1:0][WORD_BITS-1:0] words;  // words[0] goes out first
    } t_frame;

    function automatic logic [1:0] eff_sel(input logic [1:0] sel);
        eff_sel = (sel > SEL_MAX) ? SEL_MAX : sel;
    endfunction

    function automatic logic [STATE_BITS-1:0] basis(input logic [1:0] sel);
        unique case (sel)
            SEL_32:  basis = BASIS_32;
            SEL_64:  basis = BASIS_64;
            SEL_128: basis = BASIS_128;
            default: basis = BASIS_256;
        endcase
    endfunction

    // multiply by a small constant through shift and add
    function automatic logic [STATE_BITS-1:0] mul_low(input logic [STATE_BITS-1:0] x,
                                                      input logic [8:0] c);
        logic [STATE_BITS-1:0] acc;
        acc = '0;
        for (int i = 0; i < 9; i++) begin
            if (c[i]) begin
                acc = acc + (x << i);
            end
        end
        mul_low = acc;
    endfunction

    // x times the prime of the width, modulo 2^width, upper bits cleared
    function automatic logic [STATE_BITS-1:0] mul_prime(input logic [STATE_BITS-1:0] x,
                                                        input logic [1:0] sel);
        logic [STATE_BITS-1:0] r;
        unique case (sel)
            SEL_32: begin
                r = mul_low(x, PRIME_LOW_32) + (x << 24);
                r = {224'd0, r[31:0]};
            end
            SEL_64: begin
                r = mul_low(x, PRIME_LOW_64) + (x << 40);
                r = {192'd0, r[63:0]};
            end
            SEL_128: begin
                r = mul_low(x, PRIME_LOW_128) + (x << 88);
                r = {128'd0, r[127:0]};
            end
            default: begin
                r = mul_low(x, PRIME_LOW_256) + (x << 168);
            end
        endcase
        mul_prime = r;
    endfunction

    function automatic logic [STATE_BITS-1:0] fnv_step(input logic [STATE_BITS-1:0] h,
                                                       input logic [7:0] b,
                                                       input logic first,
                                                       input logic variant,
                                                       input logic [1:0] sel);
        logic [STATE_BITS-1:0] x;
        x = first ? basis(sel) : h;
        if (variant) begin
            x[7:0] = x[7:0] ^ b;
            x      = mul_prime(x, sel);
        end else begin
            x      = mul_prime(x, sel);
            x[7:0] = x[7:0] ^ b;
        end
        fnv_step = x;
    endfunction

    // hash words, most significant first, and their count
    function automatic t_frame make_frame(input logic [STATE_BITS-1:0] h,
                                          input logic [1:0] sel);
        t_frame f;
        f.valid = 1'b1;
        f.words = '0;
        unique case (sel)
            SEL_32, SEL_64: begin
                f.cnt      = CNT_W'(1);
                f.words[0] = h[63:0];
            end
            SEL_128: begin
                f.cnt      = CNT_W'(2);
                f.words[0] = h[127:64];
                f.words[1] = h[63:0];
            end
            default: begin
                f.cnt      = CNT_W'(4);
                f.words[0] = h[255:192];
                f.words[1] = h[191:128];
                f.words[2] = h[127:64];
                f.words[3] = h[63:0];
            end
        endcase
        make_frame = f;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fnvh_core.sv =====
// input beat register, config registers and running hash state
`default_nettype none
module fnvh_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [fnvh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fnvh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_valid,
    output      logic                             o_ready,
    input  wire logic [7:0]                       i_byte,
    input  wire logic                             i_first,
    input  wire logic                             i_last,
    input  wire logic                             i_out_free,
    output      fnvh_pkg::t_frame                 o_frame
);

    logic                               r_variant;
    logic [1:0]                         r_width_sel;
    logic [fnvh_pkg::STATE_BITS-1:0]    r_state;
    logic                               r_in_valid;
    logic [7:0]                         r_in_byte;
    logic                               r_in_first;
    logic                               r_in_last;

    logic [1:0]                         sel;
    logic                               fire;
    logic [fnvh_pkg::STATE_BITS-1:0]    n_state;

    assign sel     = fnvh_pkg::eff_sel(r_width_sel);
    // a last beat waits until the output side can take its words
    assign fire    = r_in_valid && (!r_in_last || i_out_free);
    assign o_ready = !r_in_valid || fire;
    assign n_state = fnvh_pkg::fnv_step(r_state, r_in_byte, r_in_first, r_variant, sel);

    always_comb begin
        o_frame       = fnvh_pkg::make_frame(n_state, sel);
        o_frame.valid = fire && r_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_variant   <= 1'b1;
            r_width_sel <= fnvh_pkg::SEL_32;
            r_state     <= fnvh_pkg::BASIS_32;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (i_cfg_we && i_cfg_idx == fnvh_pkg::REG_VARIANT) begin
                r_variant <= i_cfg_data[0];
            end
            if (i_cfg_we && i_cfg_idx == fnvh_pkg::REG_WIDTH_SEL) begin
                r_width_sel <= i_cfg_data[1:0];
                r_state     <= fnvh_pkg::basis(fnvh_pkg::eff_sel(i_cfg_data[1:0]));
            end else if (fire) begin
                // end of message restarts from the basis
                r_state <= r_in_last ? fnvh_pkg::basis(sel) : n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_byte  <= i_byte;
            r_in_first <= i_first;
            r_in_last  <= i_last;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fnvh_out.sv =====
// output word shifter for one finished hash
`default_nettype none
module fnvh_out (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fnvh_pkg::t_frame                    i_frame,
    output      logic                                o_free,
    output      logic                                o_valid,
    input  wire logic                                i_ready,
    output      logic [fnvh_pkg::WORD_BITS-1:0]      o_word,
    output      logic                                o_final
);

    logic [fnvh_pkg::NUM_WORDS-1:0][fnvh_pkg::WORD_BITS-1:0] r_q;
    logic [fnvh_pkg::CNT_W-1:0]                              r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_word  = r_q[0];
    assign o_final = r_cnt == fnvh_pkg::CNT_W'(1);
    assign o_free  = !o_valid || (o_final && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_frame.valid) begin
            r_cnt <= i_frame.cnt;
        end else if (o_valid && i_ready) begin
            r_cnt <= r_cnt - fnvh_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.valid) begin
            r_q <= i_frame.words;
        end else if (o_valid && i_ready) begin
            for (int i = 0; i < fnvh_pkg::NUM_WORDS - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
            r_q[fnvh_pkg::NUM_WORDS-1] <= '0;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fnv_byte_stream_hash_core.sv =====
// top level of the fnv-1 / fnv-1a byte stream hash
// datapath: a byte is registered on accept and then folded into the hash state; a last
//   beat's hash words are registered in the output shifter, which offers the first one
// throughput: one byte per cycle; a last beat holds the input until the previous hash's
//   words (one, two or four 64-bit beats) are drained by the output shifter
// reset: synchronous active low; variant fnv-1a, 32-bit width, 32-bit offset basis loaded
`default_nettype none
module fnv_byte_stream_hash_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // config write port: index 0 variant, index 1 width_select
    input  wire logic                             i_cfg_we,
    input  wire logic [fnvh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fnvh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // byte stream in
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  wire logic                             s_tuser,   // [0] first_byte
    input  wire logic                             s_tlast,   // last_byte
    // hash words out
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [fnvh_pkg::WORD_BITS-1:0]   m_tdata,   // [63:0] hash_word
    output      logic                             m_tlast    // final_word
);

    // finished hash passed from the state to the output shifter
    fnvh_pkg::t_frame frame;
    // output shifter can take a new hash this cycle
    logic             out_free;

    // input register, config and hash state update
    fnvh_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_byte     (s_tdata),
        .i_first    (s_tuser),
        .i_last     (s_tlast),
        .i_out_free (out_free),
        .o_frame    (frame)
    );

    // words go out most significant first, tlast on the final one
    fnvh_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame),
        .o_free  (out_free),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_word  (m_tdata),
        .o_final (m_tlast)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the fnv-1 / fnv-1a byte stream hash core: directed table, random messages
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // register indexes the block does not decode, written to check they are ignored
    localparam logic [fnvh_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [fnvh_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int RAND_ITEMS  = 180;   // random beats after the directed table
    localparam int HOLD_AT     = 60;    // random beat count that starts the long output stall
    localparam int LONG_HOLD   = 300;   // cycles the receiver stays not ready
    localparam int SETTLE      = 8;     // cycles for an in-flight byte to fold into the state
    localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either side before giving up
    localparam int DIR_ROWS    = 20;

    // one hash beat as it should leave the block
    typedef struct packed {
        logic [fnvh_pkg::WORD_BITS-1:0] word;
        logic                           fin;
    } t_hash_beat;

    // directed row: configuration it runs under, the byte, and an optional fixed hash word
    typedef struct packed {
        logic                           vrnt;
        logic [1:0]                     wsel;
        logic [7:0]                     data;
        logic                           first;
        logic                           last;
        logic                           chk;
        logic [fnvh_pkg::WORD_BITS-1:0] want;
    } t_dir_row;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #10 i_clk = ~i_clk;

    // block inputs, all known from time zero
    logic                            i_cfg_we   = 1'b0;
    logic [fnvh_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [fnvh_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            s_tvalid   = 1'b0;
    logic [7:0]                      s_tdata    = '0;   // [7:0] data_byte
    logic                            s_tuser    = 1'b0; // [0] first_byte
    logic                            s_tlast    = 1'b0; // last_byte
    logic                            m_tready   = 1'b0;

    // block outputs
    logic                            s_tready;
    logic                            m_tvalid;
    logic [fnvh_pkg::WORD_BITS-1:0]  m_tdata;           // [63:0] hash_word
    logic                            m_tlast;           // final_word

    fnv_byte_stream_hash_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // ------------------------------------------------------------------
    // hash predictor: own copy of state and registers
    // ------------------------------------------------------------------
    logic [255:0] hash_st;
    logic         cfg_var;
    logic [1:0]   cfg_ws;
    t_hash_beat   hash_expect_q [$];

    int mismatches = 0;

    // width code clipped to what the block is built for, never below 32 bits
    function automatic logic [1:0] fit_sel(input logic [1:0] sel);
        logic [1:0] s;
        s = sel;
        while (s != fnvh_pkg::SEL_32 && (32 << s) > fnvh_pkg::MAX_HASH_BITS)
            s = s - 2'd1;
        return s;
    endfunction

    function automatic logic [255:0] basis_of(input logic [1:0] sel);
        case (sel)
            fnvh_pkg::SEL_32:  return {224'd0, 32'h811c9dc5};
            fnvh_pkg::SEL_64:  return {192'd0, 64'hcbf29ce484222325};
            fnvh_pkg::SEL_128: return {128'd0, 64'h6c62272e07bb0142, 64'h62b821756295c58d};
            default: return {64'hdd268dbcaac55036, 64'h2d98c384c4e576cc,
                             64'hc8b1536847b6bbb3, 64'h1023b4c8caee0535};
        endcase
    endfunction

    // full-width product with the fnv prime, kept modulo 2^width
    function automatic logic [255:0] times_prime(input logic [255:0] h, input logic [1:0] sel);
        logic [255:0] p;
        logic [255:0] keep;
        case (sel)
            fnvh_pkg::SEL_32:  p = (256'd1 << 24)  + 256'h193;
            fnvh_pkg::SEL_64:  p = (256'd1 << 40)  + 256'h1b3;
            fnvh_pkg::SEL_128: p = (256'd1 << 88)  + 256'h13b;
            default:           p = (256'd1 << 168) + 256'h163;
        endcase
        keep = {256{1'b1}} >> (256 - (32 << sel));
        return (h * p) & keep;
    endfunction

    // fold one accepted byte; on a last byte queue the hash words, top word first
    task automatic fold_beat(input logic [7:0] b, input logic f, input logic l,
                             input logic chk, input logic [fnvh_pkg::WORD_BITS-1:0] typed);
        logic [1:0] s;
        int         nw;
        t_hash_beat e;
        s = fit_sel(cfg_ws);
        if (f)
            hash_st = basis_of(s);
        if (cfg_var) begin
            hash_st[7:0] = hash_st[7:0] ^ b;
            hash_st      = times_prime(hash_st, s);
        end else begin
            hash_st      = times_prime(hash_st, s);
            hash_st[7:0] = hash_st[7:0] ^ b;
        end
        if (l) begin
            nw = (s < fnvh_pkg::SEL_128) ? 1 : ((s == fnvh_pkg::SEL_128) ? 2 : 4);
            for (int k = 0; k < nw; k++) begin
                e.word = hash_st[64*(nw-1-k) +: 64];
                e.fin  = (k == nw - 1);
                // known vectors replace the predicted word on single-word rows
                if (chk)
                    e.word = typed;
                hash_expect_q.push_back(e);
            end
            // next message starts from the basis even without a first mark
            hash_st = basis_of(s);
        end
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [fnvh_pkg::WORD_BITS-1:0] got,
                                   input logic [fnvh_pkg::WORD_BITS-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // idle lengths: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int idle_len();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // output side: random ready, calm stretches, one long hold-off on request
    // ------------------------------------------------------------------
    logic long_hold_go   = 1'b0;
    bit   long_hold_done = 1'b0;
    int   hold_left      = 0;
    int   gap_left       = 0;
    int   calm_left      = 0;
    bit   rx_calm        = 1'b0;

    always @(posedge i_clk) begin
        if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
        end
        // at the start of each calm stretch re-pick whether this stretch stalls at all
        if (calm_left == 0) begin
            calm_left = 50;
            rx_calm   = ($urandom_range(0, 3) == 0);
        end
        calm_left = calm_left - 1;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            m_tready <= 1'b0;
        end else if (rx_calm || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
        end else begin
            gap_left = idle_len() - 1;
            m_tready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result checker: each hash beat against the oldest expectation
    // ------------------------------------------------------------------
    t_hash_beat got_exp;

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (hash_expect_q.size() == 0) begin
                report_mismatch("hash beat with nothing expected", m_tdata, '0);
            end else begin
                got_exp = hash_expect_q.pop_front();
                if (m_tdata !== got_exp.word)
                    report_mismatch("hash_word", m_tdata, got_exp.word);
                if (m_tlast !== got_exp.fin)
                    report_mismatch("final_word", {63'd0, m_tlast}, {63'd0, got_exp.fin});
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no beat on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("FAIL fnv_byte_stream_hash_core");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    bit tx_calm = 1'b0;

    // offer one byte beat, hold it until taken, then fold it into the prediction
    task automatic send_beat(input logic [7:0] b, input logic f, input logic l,
                             input logic chk, input logic [fnvh_pkg::WORD_BITS-1:0] typed);
        int gap;
        gap = (tx_calm || $urandom_range(0, 9) < 6) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= f;
        s_tlast  <= l;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        fold_beat(b, f, l, chk, typed);
    endtask

    // stop sending, wait for every expected hash beat, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (hash_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one register write; unknown indexes leave the predictor alone
    task automatic cfg_write(input logic [fnvh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fnvh_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == fnvh_pkg::REG_VARIANT) begin
            cfg_var = data[0];
        end else if (idx == fnvh_pkg::REG_WIDTH_SEL) begin
            cfg_ws  = data[1:0];
            hash_st = basis_of(fit_sel(cfg_ws));
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    t_dir_row dir_tab [0:DIR_ROWS-1];

    initial begin
        bit         var_diff;
        bit         ws_diff;
        int         rand_items;
        int         phase;
        int         nmsg;
        int         len;
        logic       v;
        logic       hi;
        logic [1:0] w;
        logic       f;
        logic       l;
        logic [1:0] spare_data;

        // reset state of the predictor: fnv-1a, 32 bits, 32-bit basis
        cfg_var = 1'b1;
        cfg_ws  = fnvh_pkg::SEL_32;
        hash_st = basis_of(fnvh_pkg::SEL_32);

        dir_tab = '{
            // right after reset, no first mark: fnv-1a 32 of "a"
            '{1'b1, fnvh_pkg::SEL_32,  8'h61, 1'b0, 1'b1, 1'b1, 64'h00000000e40c292c},
            // known single-byte vectors for the other variant and 64 bits
            '{1'b0, fnvh_pkg::SEL_32,  8'h61, 1'b1, 1'b1, 1'b1, 64'h00000000050c5d7e},
            '{1'b0, fnvh_pkg::SEL_64,  8'h61, 1'b1, 1'b1, 1'b1, 64'haf63bd4c8601b7be},
            '{1'b1, fnvh_pkg::SEL_64,  8'h61, 1'b1, 1'b1, 1'b1, 64'haf63dc4c8601ec8c},
            // byte extremes, then a variant flip mid-message keeps the state
            '{1'b1, fnvh_pkg::SEL_64,  8'h00, 1'b1, 1'b0, 1'b0, 64'h0},
            '{1'b1, fnvh_pkg::SEL_64,  8'hff, 1'b0, 1'b0, 1'b0, 64'h0},
            '{1'b0, fnvh_pkg::SEL_64,  8'h5a, 1'b0, 1'b1, 1'b0, 64'h0},
            // 128 bits: one-byte message, then one with no first mark
            '{1'b0, fnvh_pkg::SEL_128, 8'hff, 1'b1, 1'b1, 1'b0, 64'h0},
            '{1'b1, fnvh_pkg::SEL_128, 8'h00, 1'b0, 1'b1, 1'b0, 64'h0},
            // width change mid-message reloads the basis
            '{1'b1, fnvh_pkg::SEL_128, 8'h12, 1'b1, 1'b0, 1'b0, 64'h0},
            '{1'b1, fnvh_pkg::SEL_256, 8'h34, 1'b0, 1'b0, 1'b0, 64'h0},
            '{1'b1, fnvh_pkg::SEL_256, 8'hff, 1'b0, 1'b1, 1'b0, 64'h0},
            '{1'b0, fnvh_pkg::SEL_256, 8'h00, 1'b1, 1'b1, 1'b0, 64'h0},
            // a first mark inside a message restarts it
            '{1'b0, fnvh_pkg::SEL_256, 8'ha5, 1'b1, 1'b0, 1'b0, 64'h0},
            '{1'b0, fnvh_pkg::SEL_256, 8'h5a, 1'b1, 1'b0, 1'b0, 64'h0},
            '{1'b0, fnvh_pkg::SEL_256, 8'hc3, 1'b0, 1'b1, 1'b0, 64'h0},
            // back to 32 bits, top bit of the byte alone
            '{1'b1, fnvh_pkg::SEL_32,  8'hff, 1'b1, 1'b1, 1'b0, 64'h0},
            '{1'b1, fnvh_pkg::SEL_32,  8'h00, 1'b0, 1'b0, 1'b0, 64'h0},
            '{1'b1, fnvh_pkg::SEL_32,  8'h80, 1'b0, 1'b1, 1'b0, 64'h0},
            '{1'b0, fnvh_pkg::SEL_64,  8'h01, 1'b1, 1'b1, 1'b0, 64'h0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; registers change only with the block idle
        for (int r = 0; r < DIR_ROWS; r++) begin
            var_diff = (dir_tab[r].vrnt != cfg_var);
            ws_diff  = (dir_tab[r].wsel != cfg_ws);
            if (var_diff || ws_diff) begin
                drain_results();
                if (var_diff)
                    cfg_write(fnvh_pkg::REG_VARIANT, {1'b0, dir_tab[r].vrnt});
                if (ws_diff)
                    cfg_write(fnvh_pkg::REG_WIDTH_SEL, dir_tab[r].wsel);
            end
            send_beat(dir_tab[r].data, dir_tab[r].first, dir_tab[r].last,
                      dir_tab[r].chk, dir_tab[r].want);
        end

        // random phases: each one drains, reprograms, then sends a few messages
        rand_items = 0;
        phase      = 0;
        while (rand_items < RAND_ITEMS) begin
            drain_results();
            // first four phases sweep every width, later ones pick freely
            if (phase < 4) begin
                w = phase[1:0];
                v = phase[0];
            end else begin
                w = 2'($urandom_range(0, 3));
                v = 1'($urandom_range(0, 1));
            end
            hi = 1'($urandom_range(0, 1));
            cfg_write(fnvh_pkg::REG_VARIANT, {hi, v});
            if (phase < 4 || $urandom_range(0, 9) < 7)
                cfg_write(fnvh_pkg::REG_WIDTH_SEL, w);
            if ($urandom_range(0, 3) == 0) begin
                spare_data = 2'($urandom_range(0, 3));
                cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, spare_data);
            end
            tx_calm = ($urandom_range(0, 3) == 0);
            nmsg    = $urandom_range(1, 5);
            for (int m = 0; m < nmsg; m++) begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
                for (int j = 0; j < len; j++) begin
                    // mostly well formed: first on the opening byte, last on the closing one
                    f = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
                    l = (j == len - 1) && !(m == nmsg - 1 && $urandom_range(0, 7) == 0);
                    send_beat(8'($urandom_range(0, 255)), f, l, 1'b0, '0);
                    rand_items++;
                    // receiver stalls for a long stretch while bytes keep coming
                    if (rand_items == HOLD_AT)
                        long_hold_go <= 1'b1;
                end
            end
            phase++;
        end

        drain_results();
        if (mismatches == 0) begin
            $display("PASS fnv_byte_stream_hash_core");
        end else begin
            $display("FAIL fnv_byte_stream_hash_core");
        end
        $finish;
    end

endmodule
`default_nettype wire
